// ===== rtl/core/btr_pkg.sv =====
// Package of shared types, codes and reset constants for the button tap/hold/repeat block.
`timescale 1ns / 1ps
package btr_pkg;

  // Number of buttons that carry a bit in the configuration masks.
  localparam int unsigned MaskBits = 5;

  // Result event codes.
  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvTap    = 2'd1,
    EvLong   = 2'd2,
    EvRepeat = 2'd3
  } event_e;

  // Configuration register indexes.
  localparam logic [2:0] RegPresentMask    = 3'd0;
  localparam logic [2:0] RegLongEnableMask = 3'd1;
  localparam logic [2:0] RegRepeatMask     = 3'd2;
  localparam logic [2:0] RegPlainLongMs    = 3'd3;
  localparam logic [2:0] RegRepeatHoldMs   = 3'd4;
  localparam logic [2:0] RegRepeatPeriodMs = 3'd5;

  // Configuration reset values.
  localparam logic [4:0]  PresentMaskRst    = 5'd31;
  localparam logic [4:0]  LongEnableMaskRst = 5'd29;
  localparam logic [4:0]  RepeatMaskRst     = 5'd28;
  localparam logic [15:0] PlainLongMsRst    = 16'd5000;
  localparam logic [15:0] RepeatHoldMsRst   = 16'd1000;
  localparam logic [15:0] RepeatPeriodMsRst = 16'd400;

  typedef struct packed {
    logic [2:0]  button;
    logic        level;
    logic        confirm_level;
    logic [31:0] now_ms;
    logic        display_sleeping;
  } in_t;

  typedef struct packed {
    logic [2:0] button_id;
    logic [1:0] event_res;
    logic       user_activity;
  } out_t;

  typedef struct packed {
    logic [4:0]  present_mask;
    logic [4:0]  long_enable_mask;
    logic [4:0]  repeat_mask;
    logic [15:0] plain_long_ms;
    logic [15:0] repeat_hold_ms;
    logic [15:0] repeat_period_ms;
  } cfg_t;

  // Per-button state record as kept in the state memory.
  typedef struct packed {
    logic        prev_level;
    logic [31:0] press_time;
    logic [31:0] long_time;
    logic        long_done;
    logic        wake_press;
  } rec_t;

  // Record value of a button that was never written: released, all else zero.
  localparam rec_t RecRst = '{prev_level: 1'b1, press_time: 32'd0, long_time: 32'd0,
                              long_done: 1'b0, wake_press: 1'b0};

  function automatic logic mask_bit(input logic [4:0] mask, input logic [2:0] idx);
    logic hit;
    hit = 1'b0;
    if (idx < 3'(MaskBits)) begin
      hit = mask[idx];
    end
    return hit;
  endfunction

endpackage

// ===== rtl/core/btr_mem.sv =====
// Per-button state memory with registered read, valid bits and write-to-read forwarding.
`timescale 1ns / 1ps
module btr_mem import btr_pkg::*; #(
  parameter int unsigned Depth = 5,
  parameter int unsigned AddrW = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output rec_t             rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  rec_t             wr_data_i
);

  rec_t             mem [Depth];
  rec_t             rd_q;
  rec_t             fwd_q;
  logic             fwd_hit_q;
  logic             rd_vld_q;
  logic [Depth-1:0] vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q  <= mem[rd_addr_i];
      fwd_q <= wr_data_i;
    end
  end

  // A write and a read of the same entry at one edge return the old data,
  // so the written record is kept aside and chosen instead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      fwd_hit_q <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
        rd_vld_q  <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_q : (rd_vld_q ? rd_q : RecRst);

endmodule

// ===== rtl/core/btr_upd.sv =====
// Per-poll update logic: edge detection, tap, long and repeat decisions.
`timescale 1ns / 1ps
module btr_upd import btr_pkg::*; #(
  parameter int unsigned NumButtons = 5
) (
  input  in_t  item_i,
  input  rec_t rec_i,
  input  cfg_t cfg_i,
  output logic wr_en_o,
  output rec_t rec_o,
  output out_t res_o
);

  localparam logic [5:0] NumB = 6'(NumButtons);

  logic        active;
  logic        has_long;
  logic        rep;
  logic [31:0] thr;
  logic [31:0] held;
  logic [31:0] since_long;
  logic        held_long;
  event_e      ev;
  logic        act;

  always_comb begin
    active     = (6'(item_i.button) < NumB) && mask_bit(cfg_i.present_mask, item_i.button);
    has_long   = mask_bit(cfg_i.long_enable_mask, item_i.button);
    rep        = mask_bit(cfg_i.repeat_mask, item_i.button);
    thr        = {16'd0, rep ? cfg_i.repeat_hold_ms : cfg_i.plain_long_ms};
    held       = item_i.now_ms - rec_i.press_time;
    since_long = item_i.now_ms - rec_i.long_time;
    held_long  = held >= thr;
    ev         = EvNone;
    act        = 1'b0;
    rec_o      = rec_i;

    if (active) begin
      if (!item_i.level && rec_i.prev_level) begin
        // Press: only counts when the debounce sample confirms it.
        if (!item_i.confirm_level) begin
          rec_o.press_time = item_i.now_ms;
          rec_o.long_done  = 1'b0;
          rec_o.wake_press = rep && item_i.display_sleeping;
          rec_o.prev_level = 1'b0;
          act              = 1'b1;
        end
      end else if (item_i.level && !rec_i.prev_level) begin
        if (!rec_i.wake_press && !rec_i.long_done && (!has_long || !held_long)) begin
          ev = EvTap;
        end
        rec_o.prev_level = 1'b1;
        rec_o.wake_press = 1'b0;
      end else if (!item_i.level && !rec_i.prev_level && has_long && !rec_i.wake_press) begin
        if (!rec_i.long_done) begin
          if (held_long) begin
            rec_o.long_done = 1'b1;
            rec_o.long_time = item_i.now_ms;
            ev              = EvLong;
          end
        end else if (rep && (since_long >= {16'd0, cfg_i.repeat_period_ms})) begin
          rec_o.long_time = item_i.now_ms;
          ev              = EvRepeat;
          act             = 1'b1;
        end
      end
    end

    wr_en_o             = active;
    res_o.button_id     = item_i.button;
    res_o.event_res     = ev;
    res_o.user_activity = act;
  end

endmodule

// ===== rtl/core/button_tap_hold_repeat.sv =====
// Top level of the button tap, long-press and auto-repeat detector.
// A poll accepted into stage one has its result registered in the output register when
// stage one moves on, and the result transaction completes once it is not stalled.
// Throughput: one poll per cycle, with forwarding between back-to-back polls of one
// button; only a stalled result holds stage one and with it the input.
// Reset: configuration returns to its defaults and all per-button valid bits clear.
`timescale 1ns / 1ps
module button_tap_hold_repeat import btr_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // After reset every button reads as released with zero times; there is no
  // clearing pass, the per-entry valid bits in the memory stand in for it.

  // Address width of the state memory; at least one bit.
  localparam int unsigned AddrW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [5:0]  NumB  = 6'(NUM_BUTTONS);

  cfg_t cfg_q;

  // Stage one holds the poll whose state record arrives from the memory.
  logic s1_vld_q;
  in_t  s1_item_q;

  // The output register parts the result side from the memory loop.
  logic out_vld_q;
  out_t out_q;

  logic in_accept;
  logic s1_hold;
  logic s1_adv;
  logic rd_en;
  rec_t rd_rec;
  rec_t upd_rec;
  logic upd_wr;
  out_t upd_res;

  // Configuration registers are always ready; a write to an unused index is
  // dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.present_mask     <= PresentMaskRst;
      cfg_q.long_enable_mask <= LongEnableMaskRst;
      cfg_q.repeat_mask      <= RepeatMaskRst;
      cfg_q.plain_long_ms    <= PlainLongMsRst;
      cfg_q.repeat_hold_ms   <= RepeatHoldMsRst;
      cfg_q.repeat_period_ms <= RepeatPeriodMsRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegPresentMask:    cfg_q.present_mask     <= cfg_data_i[4:0];
        RegLongEnableMask: cfg_q.long_enable_mask <= cfg_data_i[4:0];
        RegRepeatMask:     cfg_q.repeat_mask      <= cfg_data_i[4:0];
        RegPlainLongMs:    cfg_q.plain_long_ms    <= cfg_data_i;
        RegRepeatHoldMs:   cfg_q.repeat_hold_ms   <= cfg_data_i;
        RegRepeatPeriodMs: cfg_q.repeat_period_ms <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Stage one moves on unless the output register is full and stalled. A new
  // transaction enters whenever stage one is empty or moving on.
  assign s1_hold    = out_vld_q && out_stall_i;
  assign s1_adv     = s1_vld_q && !s1_hold;
  assign in_stall_o = s1_vld_q && s1_hold;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Polls of a button beyond the memory depth never touch the memory.
  assign rd_en = in_accept && (6'(in_data_i.button) < NumB);

  btr_mem #(
    .Depth (NUM_BUTTONS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (AddrW'(in_data_i.button)),
    .rd_data_o (rd_rec),
    .wr_en_i   (s1_adv && upd_wr),
    .wr_addr_i (AddrW'(s1_item_q.button)),
    .wr_data_i (upd_rec)
  );

  btr_upd #(
    .NumButtons (NUM_BUTTONS)
  ) u_upd (
    .item_i  (s1_item_q),
    .rec_i   (rd_rec),
    .cfg_i   (cfg_q),
    .wr_en_o (upd_wr),
    .rec_o   (upd_rec),
    .res_o   (upd_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_data_i;
    end
    if (s1_adv) begin
      out_q <= upd_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
